// ===== rtl/core/swm_pkg.sv =====
// Shared constants and control structs of the sliding window median unit.
package swm_pkg;

    localparam int SWM_MAX_WINDOW  = 64;
    localparam int SWM_SAMPLE_BITS = 32;
    localparam int SWM_CFG_BITS    = 7;

    localparam logic [SWM_CFG_BITS-1:0] SWM_WINDOW_RESET = SWM_CFG_BITS'(3);

    // control from the top level to the cell row
    typedef struct packed {
        logic step;      // an item is accepted this cycle
        logic emit;      // window becomes full: give the median, evict the oldest
        logic clear;     // empty the window
        logic size_one;  // window of one: the oldest is the new item itself
    } t_chain_ctrl;

    // control broadcast to every cell
    typedef struct packed {
        logic step;
        logic emit;
        logic clear;
        logic key_ge;    // new item >= value being evicted
    } t_cell_ctrl;

endpackage

// ===== rtl/core/swm_if.sv =====
// Handshake channels of the sliding window median unit: sample in, median out, config.
interface swm_sample_if #(parameter int SAMPLE_BITS = 32);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swm_median_if #(parameter int SAMPLE_BITS = 32);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] median;

    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);
endinterface

interface swm_cfg_if #(parameter int CFG_BITS = 7);
    logic                valid;
    logic                ready;
    logic [CFG_BITS-1:0] window_size;

    modport source (output valid, output window_size, input ready);
    modport sink   (input valid, input window_size, output ready);
endinterface

// ===== rtl/core/swm_cell.sv =====
// One cell of the sorted row: holds one window entry and its age.
module swm_cell
    import swm_pkg::*;
#(
    parameter int SAMPLE_BITS = SWM_SAMPLE_BITS,
    parameter int AGE_BITS    = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cell_ctrl                    i_ctrl,
    input  logic signed [SAMPLE_BITS-1:0] i_key,
    input  logic signed [SAMPLE_BITS-1:0] i_old_key,
    input  logic [AGE_BITS-1:0]           i_age_tgt,
    // left neighbor, current contents
    input  logic                          i_left_val,
    input  logic signed [SAMPLE_BITS-1:0] i_left_key,
    input  logic [AGE_BITS-1:0]           i_left_age,
    input  logic                          i_left_stays,
    input  logic                          i_left_ge,
    // right neighbor, after insertion
    input  logic                          i_right_ins_val,
    input  logic signed [SAMPLE_BITS-1:0] i_right_ins_key,
    input  logic [AGE_BITS-1:0]           i_right_ins_age,
    // own contents
    output logic                          o_val,
    output logic signed [SAMPLE_BITS-1:0] o_key,
    output logic [AGE_BITS-1:0]           o_age,
    output logic                          o_stays,
    output logic                          o_ge,
    output logic                          o_aged,
    // own entry after insertion of the new item
    output logic                          o_ins_val,
    output logic signed [SAMPLE_BITS-1:0] o_ins_key,
    output logic [AGE_BITS-1:0]           o_ins_age
);

    logic                          r_val;
    logic signed [SAMPLE_BITS-1:0] r_key;
    logic [AGE_BITS-1:0]           r_age;
    logic                          n_val;
    logic signed [SAMPLE_BITS-1:0] n_key;
    logic [AGE_BITS-1:0]           n_age;
    logic                          w_ins_ge;

    assign o_val   = r_val;
    assign o_key   = r_key;
    assign o_age   = r_age;
    // equal values keep their place, so the new item lands after them
    assign o_stays = r_val && !(r_key > i_key);
    assign o_ge    = r_val && (r_key >= i_old_key);
    assign o_aged  = r_val && (r_age == i_age_tgt);

    always_comb begin
        if (o_stays) begin
            o_ins_val = 1'b1;
            o_ins_key = r_key;
            o_ins_age = r_age + AGE_BITS'(1);
            w_ins_ge  = o_ge;
        end else if (i_left_stays) begin
            o_ins_val = 1'b1;
            o_ins_key = i_key;
            o_ins_age = '0;
            w_ins_ge  = i_ctrl.key_ge;
        end else begin
            o_ins_val = i_left_val;
            o_ins_key = i_left_key;
            o_ins_age = i_left_age + AGE_BITS'(1);
            w_ins_ge  = i_left_ge;
        end
    end

    // eviction: everything from the oldest entry onward moves one cell left
    always_comb begin
        if (i_ctrl.emit && w_ins_ge) begin
            n_val = i_right_ins_val;
            n_key = i_right_ins_key;
            n_age = i_right_ins_age;
        end else begin
            n_val = o_ins_val;
            n_key = o_ins_key;
            n_age = o_ins_age;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_val <= 1'b0;
        end else if (i_ctrl.step) begin
            r_val <= n_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.step) begin
            r_key <= n_key;
            r_age <= n_age;
        end
    end

endmodule

// ===== rtl/core/swm_chain.sv =====
// Row of sorted cells with oldest-entry lookup and median select.
module swm_chain
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW  = SWM_MAX_WINDOW,
    parameter int SAMPLE_BITS = SWM_SAMPLE_BITS,
    parameter int AGE_BITS    = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_chain_ctrl                   i_ctrl,
    input  logic signed [SAMPLE_BITS-1:0] i_key,
    input  logic [AGE_BITS-1:0]           i_age_tgt,
    input  logic [AGE_BITS-1:0]           i_mid_idx,
    output logic signed [SAMPLE_BITS-1:0] o_median
);

    logic                          w_val     [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] w_key     [MAX_WINDOW];
    logic [AGE_BITS-1:0]           w_age     [MAX_WINDOW];
    logic                          w_stays   [MAX_WINDOW];
    logic                          w_ge      [MAX_WINDOW];
    logic                          w_aged    [MAX_WINDOW];
    logic                          w_ins_val [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] w_ins_key [MAX_WINDOW];
    logic [AGE_BITS-1:0]           w_ins_age [MAX_WINDOW];

    logic [SAMPLE_BITS-1:0]        w_aged_or;
    logic signed [SAMPLE_BITS-1:0] w_old_key;
    t_cell_ctrl                    w_cell_ctrl;

    // at most one valid cell carries the evicted age
    always_comb begin
        w_aged_or = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            w_aged_or = w_aged_or | (w_aged[i] ? w_key[i] : '0);
        end
    end

    assign w_old_key = i_ctrl.size_one ? i_key : $signed(w_aged_or);

    assign w_cell_ctrl.step   = i_ctrl.step;
    assign w_cell_ctrl.emit   = i_ctrl.emit;
    assign w_cell_ctrl.clear  = i_ctrl.clear;
    assign w_cell_ctrl.key_ge = (i_key >= w_old_key);

    assign o_median = w_ins_key[i_mid_idx];

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        logic                          w_left_val;
        logic signed [SAMPLE_BITS-1:0] w_left_key;
        logic [AGE_BITS-1:0]           w_left_age;
        logic                          w_left_stays;
        logic                          w_left_ge;
        logic                          w_right_val;
        logic signed [SAMPLE_BITS-1:0] w_right_key;
        logic [AGE_BITS-1:0]           w_right_age;

        if (g == 0) begin : g_first
            // head of the row: the new item goes here unless cell 0 stays
            assign w_left_val   = 1'b0;
            assign w_left_key   = '0;
            assign w_left_age   = '0;
            assign w_left_stays = 1'b1;
            assign w_left_ge    = 1'b0;
        end else begin : g_inner_left
            assign w_left_val   = w_val[g-1];
            assign w_left_key   = w_key[g-1];
            assign w_left_age   = w_age[g-1];
            assign w_left_stays = w_stays[g-1];
            assign w_left_ge    = w_ge[g-1];
        end

        if (g == MAX_WINDOW - 1) begin : g_last
            assign w_right_val = 1'b0;
            assign w_right_key = '0;
            assign w_right_age = '0;
        end else begin : g_inner_right
            assign w_right_val = w_ins_val[g+1];
            assign w_right_key = w_ins_key[g+1];
            assign w_right_age = w_ins_age[g+1];
        end

        swm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .AGE_BITS    (AGE_BITS)
        ) u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_ctrl          (w_cell_ctrl),
            .i_key           (i_key),
            .i_old_key       (w_old_key),
            .i_age_tgt       (i_age_tgt),
            .i_left_val      (w_left_val),
            .i_left_key      (w_left_key),
            .i_left_age      (w_left_age),
            .i_left_stays    (w_left_stays),
            .i_left_ge       (w_left_ge),
            .i_right_ins_val (w_right_val),
            .i_right_ins_key (w_right_key),
            .i_right_ins_age (w_right_age),
            .o_val           (w_val[g]),
            .o_key           (w_key[g]),
            .o_age           (w_age[g]),
            .o_stays         (w_stays[g]),
            .o_ge            (w_ge[g]),
            .o_aged          (w_aged[g]),
            .o_ins_val       (w_ins_val[g]),
            .o_ins_key       (w_ins_key[g]),
            .o_ins_age       (w_ins_age[g])
        );
    end

endmodule

// ===== rtl/core/sliding_window_median_unit.sv =====
// Top level of the sliding window median unit: handshakes, window size, fill count.
//
// Running lower-median filter over signed samples. The window is held in a row of
// MAX_WINDOW cells kept in ascending order; every cell also tracks the age of its entry.
// An accepted item is inserted and, once the window is full, the lower median is taken
// and the oldest entry evicted, all in the same clock: the unit takes one item per cycle
// and the median appears on the output register in the cycle after the item that fills the
// window. Only a median left waiting in the output register while the output stalls
// holds the input off. No result is given while the window fills. Writing window_size
// (0 acts as 1, values above MAX_WINDOW act as MAX_WINDOW) empties the window; write it
// only while no item is in flight.
module sliding_window_median_unit
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW  = SWM_MAX_WINDOW,
    parameter int SAMPLE_BITS = SWM_SAMPLE_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    swm_sample_if.sink i_in,
    swm_median_if.source o_out,
    swm_cfg_if.sink    i_cfg
);

    localparam int FILL_BITS = $clog2(MAX_WINDOW + 1);
    localparam int SIZE_BITS = (SWM_CFG_BITS > FILL_BITS) ? SWM_CFG_BITS : FILL_BITS;
    localparam int AGE_BITS  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    logic [SWM_CFG_BITS-1:0]       r_window_size;
    logic [FILL_BITS-1:0]          r_fill;
    logic [FILL_BITS-1:0]          n_fill;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_median;

    logic [SIZE_BITS-1:0]          w_ws;
    logic [SIZE_BITS-1:0]          w_size;
    logic [SIZE_BITS-1:0]          w_size_m1;
    logic                          w_step;
    logic                          w_emit;
    logic                          w_cfg_wr;
    t_chain_ctrl                   w_chain_ctrl;
    logic [AGE_BITS-1:0]           w_age_tgt;
    logic [AGE_BITS-1:0]           w_mid_idx;
    logic signed [SAMPLE_BITS-1:0] w_median;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_wr    = i_cfg.valid && i_cfg.ready;

    assign w_ws = SIZE_BITS'(r_window_size);

    always_comb begin
        if (w_ws == '0) begin
            w_size = SIZE_BITS'(1);
        end else if (w_ws > SIZE_BITS'(MAX_WINDOW)) begin
            w_size = SIZE_BITS'(MAX_WINDOW);
        end else begin
            w_size = w_ws;
        end
    end

    assign w_size_m1 = w_size - SIZE_BITS'(1);
    assign w_age_tgt = AGE_BITS'(w_size - SIZE_BITS'(2));
    assign w_mid_idx = AGE_BITS'(w_size_m1 >> 1);

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_step     = i_in.valid && i_in.ready;
    assign w_emit     = (SIZE_BITS'(r_fill) == w_size_m1);

    assign w_chain_ctrl.step     = w_step;
    assign w_chain_ctrl.emit     = w_emit;
    assign w_chain_ctrl.clear    = w_cfg_wr;
    assign w_chain_ctrl.size_one = (w_size == SIZE_BITS'(1));

    swm_chain #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .AGE_BITS    (AGE_BITS)
    ) u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_chain_ctrl),
        .i_key     (i_in.sample),
        .i_age_tgt (w_age_tgt),
        .i_mid_idx (w_mid_idx),
        .o_median  (w_median)
    );

    // full window keeps its count: one in, one out
    assign n_fill = w_emit ? r_fill : r_fill + FILL_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= SWM_WINDOW_RESET;
            r_fill        <= '0;
        end else if (w_cfg_wr) begin
            r_window_size <= i_cfg.window_size;
            r_fill        <= '0;
        end else if (w_step) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_emit) begin
            r_median <= w_median;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.median = r_median;

endmodule

// ===== test/sliding_window_median_checker.sv =====
// Checker for the sliding window median unit: tracks the window, predicts each median, compares.
module sliding_window_median_checker
    import swm_pkg::*;
(
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic signed [SWM_SAMPLE_BITS-1:0] i_in_sample,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic signed [SWM_SAMPLE_BITS-1:0] i_out_median,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [SWM_CFG_BITS-1:0]           i_cfg_window_size,
    output int                                o_mismatches,
    output int                                o_medians_due
);

    typedef logic signed [SWM_SAMPLE_BITS-1:0] t_sample;

    t_sample                 arrival [SWM_MAX_WINDOW];   // window in arrival order
    t_sample                 ordered [SWM_MAX_WINDOW];   // window in ascending order
    int                      held;
    int                      next_slot;
    logic [SWM_CFG_BITS-1:0] window_reg;
    t_sample                 expected_medians[$];
    int                      mismatches = 0;
    t_sample                 want;

    function automatic int window_length(input logic [SWM_CFG_BITS-1:0] ws);
        if (ws == 0)
            return 1;
        if (ws > SWM_MAX_WINDOW)
            return SWM_MAX_WINDOW;
        return int'(ws);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("median mismatch: %s", msg);
        mismatches++;
    endtask

    function automatic void predict_median(input t_sample s);
        int      size;
        int      i;
        t_sample oldest;
        size = window_length(window_reg);
        if (next_slot >= size)
            next_slot = 0;
        if (held >= size)
            held = size - 1;
        arrival[next_slot] = s;
        next_slot++;
        if (next_slot >= size)
            next_slot = 0;
        i = held;
        while (i > 0 && ordered[i-1] > s) begin
            ordered[i] = ordered[i-1];
            i--;
        end
        ordered[i] = s;
        held++;
        if (held < size)
            return;
        expected_medians.push_back(ordered[(size - 1) / 2]);
        // evict one copy of the oldest value
        oldest = arrival[next_slot];
        i = 0;
        while (i < held && ordered[i] !== oldest)
            i++;
        if (i < held) begin
            while (i + 1 < held) begin
                ordered[i] = ordered[i+1];
                i++;
            end
            held--;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held       = 0;
            next_slot  = 0;
            window_reg = SWM_WINDOW_RESET;
            expected_medians.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                window_reg = i_cfg_window_size;
                held       = 0;
                next_slot  = 0;
            end
            if (i_in_valid && i_in_ready)
                predict_median(i_in_sample);
            if (i_out_valid && i_out_ready) begin
                if (expected_medians.size() == 0) begin
                    report_mismatch($sformatf("got %0d with nothing expected", i_out_median));
                end else begin
                    want = expected_medians.pop_front();
                    if (want !== i_out_median)
                        report_mismatch($sformatf("got %0d, expected %0d",
                                                  i_out_median, want));
                end
            end
        end
        o_medians_due <= expected_medians.size();
        o_mismatches  <= mismatches;
    end

endmodule

// ===== test/sliding_window_median_unit_test.sv =====
// Testbench top of the sliding window median unit: clock, reset, stimulus and verdict.
module sliding_window_median_unit_test;
    import swm_pkg::*;

    typedef logic signed [SWM_SAMPLE_BITS-1:0] t_sample;

    localparam int RANDOM_ITEMS = 1500;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 4;    // the median is registered, so it lags its item
    localparam int DRAIN_CYCLES = 20;

    localparam int MODE_SRC     = 1;
    localparam int MODE_SNK     = 2;
    localparam int MODE_BOTH    = 3;

    logic clk;
    logic rst_n;
    int   idle_pct    = 0;
    int   stall_pct   = 0;
    int   cycle_count = 0;
    int   mismatches;
    int   medians_due;

    swm_sample_if #(.SAMPLE_BITS(SWM_SAMPLE_BITS)) in_ch ();
    swm_median_if #(.SAMPLE_BITS(SWM_SAMPLE_BITS)) out_ch ();
    swm_cfg_if    #(.CFG_BITS(SWM_CFG_BITS))       cfg_ch ();

    sliding_window_median_unit uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    sliding_window_median_checker median_check (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_ch.valid),
        .i_in_ready        (in_ch.ready),
        .i_in_sample       (in_ch.sample),
        .i_out_valid       (out_ch.valid),
        .i_out_ready       (out_ch.ready),
        .i_out_median      (out_ch.median),
        .i_cfg_valid       (cfg_ch.valid),
        .i_cfg_ready       (cfg_ch.ready),
        .i_cfg_window_size (cfg_ch.window_size),
        .o_mismatches      (mismatches),
        .o_medians_due     (medians_due)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[sliding_window_median_unit] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99, 0) >= stall_pct);

    function automatic t_sample rand_sample();
        case ($urandom_range(3, 0))
            0: return t_sample'(int'($urandom_range(8, 0)) - 4);  // many repeats
            1: begin
                case ($urandom_range(3, 0))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic set_mode(input int mode);
        case (mode)
            MODE_SRC: begin
                idle_pct  = 87;
                stall_pct = 0;
            end
            MODE_SNK: begin
                idle_pct  = 0;
                stall_pct = 87;
            end
            MODE_BOTH: begin
                idle_pct  = 32;
                stall_pct = 32;
            end
            default: begin
                idle_pct  = 0;
                stall_pct = 0;
            end
        endcase
    endtask

    // valid stays high across back-to-back items; end_burst lowers it
    task automatic send_sample(input t_sample s);
        while ($urandom_range(99, 0) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.sample <= s;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic end_burst();
        in_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (medians_due != 0)
            @(posedge clk);
    endtask

    task automatic write_window(input logic [SWM_CFG_BITS-1:0] ws);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.window_size <= ws;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_burst(input t_sample run[]);
        foreach (run[k])
            send_sample(run[k]);
        end_burst();
    endtask

    initial begin
        int                      phase;
        int                      sent;
        int                      len;
        int                      count;
        logic [SWM_CFG_BITS-1:0] ws;

        rst_n              <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.sample       <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.window_size <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // window of three out of reset: extremes and runs of equal values
        send_burst('{32'sh8000_0000, 32'sh7fff_ffff, 0, -1, -1, -1, 7, 7,
                     32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
                     32'sh7fff_ffff, 32'sh7fff_ffff, 3});
        // window of one: the oldest is the item itself
        write_window(SWM_CFG_BITS'(1));
        send_burst('{5, -5});
        // size zero acts as one
        write_window(SWM_CFG_BITS'(0));
        send_burst('{9, 32'sh8000_0000});
        write_window(SWM_CFG_BITS'(2));
        send_burst('{4, 4, 1});

        phase = 0;
        sent  = 0;
        while (sent < RANDOM_ITEMS) begin
            set_mode(phase % 5);
            if (phase == 0)
                ws = SWM_CFG_BITS'(127);
            else if (phase == 1)
                ws = SWM_CFG_BITS'(SWM_MAX_WINDOW);
            else begin
                case ($urandom_range(9, 0))
                    0: ws = SWM_CFG_BITS'(SWM_MAX_WINDOW);
                    1: ws = SWM_CFG_BITS'($urandom_range(127, SWM_MAX_WINDOW + 1));
                    2: ws = SWM_CFG_BITS'(0);
                    3: ws = SWM_CFG_BITS'(1);
                    default: ws = SWM_CFG_BITS'($urandom_range(12, 2));
                endcase
            end
            write_window(ws);
            len   = (ws == 0) ? 1 : (ws > SWM_MAX_WINDOW) ? SWM_MAX_WINDOW : int'(ws);
            count = len + int'($urandom_range(60, 5));
            repeat (count)
                send_sample(rand_sample());
            end_burst();
            sent += count;
            phase++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[sliding_window_median_unit] OK");
        else
            $display("[sliding_window_median_unit] ERROR");
        $finish;
    end

endmodule
